[src/uerm_pkg.sv]
// Package for the four-channel ultrasonic echo ranger with median-of-four filter.
// Holds payload structs, controller/datapath command types and arithmetic constants.
// Used by uerm_ctrl, uerm_dp and ultrasonic_echo_ranger_median_top.
`default_nettype none

package uerm_pkg;

    // Geometry
    localparam int CHANNELS   = 4;
    localparam int CH_W       = 2;
    localparam int TIME_WIDTH = 32;
    localparam int RING_DEPTH = 4;
    localparam int PTR_W      = 2;
    localparam int SPEED_W    = 12;
    localparam int DIST_W     = 24;

    // Arithmetic widths
    localparam int T8_W   = TIME_WIDTH - 3;     // ticks / 8
    localparam int Q_W    = 27;                 // ticks / 40
    localparam int P_W    = Q_W + SPEED_W;      // quotient times speed
    localparam int PROD1_W = T8_W + 32;
    localparam int PROD2_W = 27 + 32;

    // x / 5 == (x * RECIP5) >> 34, exact for any 32-bit x
    localparam logic [31:0] RECIP5      = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 34;

    // p / 40 reaches 2^24 at this bound
    localparam logic [P_W-1:0] DIST_LIMIT = P_W'(64'd671088640);
    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    localparam logic [SPEED_W-1:0] SPEED_RESET = 12'd3435;

    typedef struct packed {
        logic [CHANNELS-1:0]   echo_lines;
        logic [TIME_WIDTH-1:0] time_now;
    } uerm_in_t;

    typedef struct packed {
        logic [CH_W-1:0]   channel;
        logic [DIST_W-1:0] raw_distance;
        logic [DIST_W-1:0] filtered_distance;
        logic              last;
    } uerm_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_WRITE,
        ST_SORT,
        ST_EMIT
    } uerm_state_t;

    // Controller -> datapath
    typedef struct packed {
        logic accept;
        logic scan;
        logic mul1;
        logic mul2;
        logic mul3;
        logic wr_ring;
        logic sort;
        logic emit;
    } uerm_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic fall_pending;
        logic out_free;
    } uerm_stat_t;

endpackage

`default_nettype wire

[src/uerm_ctrl.sv]
// Sequencer for the echo ranger: walks each falling edge through the datapath.
// Depends on uerm_pkg for the state enum and the command/status structs.
`default_nettype none

module uerm_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire uerm_pkg::uerm_stat_t stat,
    output uerm_pkg::uerm_cmd_t       cmd
);

    uerm_pkg::uerm_state_t state_reg;
    uerm_pkg::uerm_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= uerm_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            uerm_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = uerm_pkg::ST_SCAN;
                end
            end
            uerm_pkg::ST_SCAN:
            begin
                if (stat.fall_pending)
                begin
                    cmd.scan   = 1'b1;
                    state_next = uerm_pkg::ST_MUL1;
                end
                else
                begin
                    state_next = uerm_pkg::ST_IDLE;
                end
            end
            uerm_pkg::ST_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = uerm_pkg::ST_MUL2;
            end
            uerm_pkg::ST_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = uerm_pkg::ST_MUL3;
            end
            uerm_pkg::ST_MUL3:
            begin
                cmd.mul3   = 1'b1;
                state_next = uerm_pkg::ST_WRITE;
            end
            uerm_pkg::ST_WRITE:
            begin
                cmd.wr_ring = 1'b1;
                state_next  = uerm_pkg::ST_SORT;
            end
            uerm_pkg::ST_SORT:
            begin
                cmd.sort   = 1'b1;
                state_next = uerm_pkg::ST_EMIT;
            end
            uerm_pkg::ST_EMIT:
            begin
                // hold until the output register can take the result
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = uerm_pkg::ST_SCAN;
                end
            end
            default:
            begin
                state_next = uerm_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[src/uerm_dp.sv]
// Datapath of the echo ranger: edge detect, rise times, tick-to-micrometre
// conversion, per-channel distance rings, median-of-four and output register.
// Depends on uerm_pkg; driven by commands from uerm_ctrl.
`default_nettype none

module uerm_dp (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire uerm_pkg::uerm_in_t              in_data,
    input  wire uerm_pkg::uerm_cmd_t             cmd,
    output uerm_pkg::uerm_stat_t                 stat,
    input  wire logic                            cfg_valid,
    input  wire logic [uerm_pkg::SPEED_W-1:0]    cfg_data,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output uerm_pkg::uerm_out_t                  out_data
);

    // Control state
    logic [uerm_pkg::SPEED_W-1:0]    speed_reg;
    logic [uerm_pkg::CHANNELS-1:0]   prev_echo_reg;
    logic [uerm_pkg::CHANNELS-1:0]   fall_mask_reg;
    logic [uerm_pkg::CHANNELS-1:0]   fall_mask_next;
    logic [uerm_pkg::TIME_WIDTH-1:0] rise_reg [uerm_pkg::CHANNELS];
    logic [uerm_pkg::DIST_W-1:0]     ring_reg [uerm_pkg::CHANNELS][uerm_pkg::RING_DEPTH];
    logic [uerm_pkg::PTR_W-1:0]      ptr_reg  [uerm_pkg::CHANNELS];
    logic                            out_valid_reg;

    // Payload registers
    logic [uerm_pkg::TIME_WIDTH-1:0] now_reg;
    logic [uerm_pkg::CH_W-1:0]       ch_reg;
    logic                            last_reg;
    logic [uerm_pkg::T8_W-1:0]       t8_reg;
    logic [uerm_pkg::Q_W-1:0]        q_reg;
    logic [uerm_pkg::P_W-1:0]        p_reg;
    logic [uerm_pkg::DIST_W-1:0]     dist_reg;
    logic [uerm_pkg::DIST_W-1:0]     lo1_reg;
    logic [uerm_pkg::DIST_W-1:0]     hi1_reg;
    logic [uerm_pkg::DIST_W-1:0]     lo2_reg;
    logic [uerm_pkg::DIST_W-1:0]     hi2_reg;
    uerm_pkg::uerm_out_t             out_reg;

    // Combinational
    logic [uerm_pkg::CH_W-1:0]       scan_ch;
    logic [uerm_pkg::CHANNELS-1:0]   low_bit;
    logic [uerm_pkg::CHANNELS-1:0]   rest_mask;
    logic [uerm_pkg::TIME_WIDTH-1:0] ticks;
    logic [uerm_pkg::PROD1_W-1:0]    prod1;
    logic [uerm_pkg::P_W-1:0]        prod_qs;
    logic [uerm_pkg::PROD2_W-1:0]    prod2;
    logic [26:0]                     p_div8;
    logic [uerm_pkg::DIST_W-1:0]     r0;
    logic [uerm_pkg::DIST_W-1:0]     r1;
    logic [uerm_pkg::DIST_W-1:0]     r2;
    logic [uerm_pkg::DIST_W-1:0]     r3;
    logic [uerm_pkg::DIST_W-1:0]     mid_lo;
    logic [uerm_pkg::DIST_W-1:0]     mid_hi;
    logic [uerm_pkg::DIST_W:0]       mid_sum;
    logic                            out_free;

    // Lowest pending falling edge
    always_comb
    begin
        scan_ch = '0;
        for (int i = uerm_pkg::CHANNELS - 1; i >= 0; i--)
        begin
            if (fall_mask_reg[i])
            begin
                scan_ch = uerm_pkg::CH_W'(i);
            end
        end
    end

    assign low_bit   = fall_mask_reg & (~fall_mask_reg + {{(uerm_pkg::CHANNELS-1){1'b0}}, 1'b1});
    assign rest_mask = fall_mask_reg & ~low_bit;
    assign ticks     = now_reg - rise_reg[scan_ch];

    // Conversion arithmetic, one multiplier per stage
    assign prod1   = t8_reg * uerm_pkg::RECIP5;
    assign prod_qs = q_reg * speed_reg;
    assign p_div8  = p_reg[29:3];
    assign prod2   = p_div8 * uerm_pkg::RECIP5;

    // Median of four: middle pair is max of the lows and min of the highs
    assign r0      = ring_reg[ch_reg][0];
    assign r1      = ring_reg[ch_reg][1];
    assign r2      = ring_reg[ch_reg][2];
    assign r3      = ring_reg[ch_reg][3];
    assign mid_lo  = (lo1_reg > lo2_reg) ? lo1_reg : lo2_reg;
    assign mid_hi  = (hi1_reg < hi2_reg) ? hi1_reg : hi2_reg;
    assign mid_sum = {1'b0, mid_lo} + {1'b0, mid_hi};

    assign out_free = !out_valid_reg || !out_stall;

    assign stat.fall_pending = |fall_mask_reg;
    assign stat.out_free     = out_free;

    // Falling edges still to be served
    always_comb
    begin
        fall_mask_next = fall_mask_reg;
        if (cmd.accept)
        begin
            fall_mask_next = prev_echo_reg & ~in_data.echo_lines;
        end
        else if (cmd.scan)
        begin
            fall_mask_next = rest_mask;
        end
    end

    // Control state: config, edges, rise times, rings, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_reg     <= uerm_pkg::SPEED_RESET;
            prev_echo_reg <= '0;
            fall_mask_reg <= '0;
            out_valid_reg <= 1'b0;
            for (int c = 0; c < uerm_pkg::CHANNELS; c++)
            begin
                rise_reg[c] <= '0;
                ptr_reg[c]  <= '0;
                for (int k = 0; k < uerm_pkg::RING_DEPTH; k++)
                begin
                    ring_reg[c][k] <= '0;
                end
            end
        end
        else
        begin
            if (cfg_valid)
            begin
                speed_reg <= cfg_data;
            end
            fall_mask_reg <= fall_mask_next;
            if (cmd.accept)
            begin
                prev_echo_reg <= in_data.echo_lines;
                for (int c = 0; c < uerm_pkg::CHANNELS; c++)
                begin
                    if (in_data.echo_lines[c] && !prev_echo_reg[c])
                    begin
                        rise_reg[c] <= in_data.time_now;
                    end
                end
            end
            if (cmd.wr_ring)
            begin
                ring_reg[ch_reg][ptr_reg[ch_reg]] <= dist_reg;
                ptr_reg[ch_reg] <= ptr_reg[ch_reg] + 1'b1;
            end
            // set on a new result wins over a completed transfer
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload pipeline
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            now_reg <= in_data.time_now;
        end
        if (cmd.scan)
        begin
            ch_reg   <= scan_ch;
            last_reg <= (rest_mask == '0);
            t8_reg   <= ticks[uerm_pkg::TIME_WIDTH-1:3];
        end
        if (cmd.mul1)
        begin
            q_reg <= prod1[uerm_pkg::RECIP_SHIFT + uerm_pkg::Q_W - 1:uerm_pkg::RECIP_SHIFT];
        end
        if (cmd.mul2)
        begin
            p_reg <= prod_qs;
        end
        if (cmd.mul3)
        begin
            if (p_reg >= uerm_pkg::DIST_LIMIT)
            begin
                dist_reg <= uerm_pkg::DIST_MAX;
            end
            else
            begin
                dist_reg <= prod2[uerm_pkg::RECIP_SHIFT + uerm_pkg::DIST_W - 1:uerm_pkg::RECIP_SHIFT];
            end
        end
        if (cmd.sort)
        begin
            lo1_reg <= (r0 < r1) ? r0 : r1;
            hi1_reg <= (r0 < r1) ? r1 : r0;
            lo2_reg <= (r2 < r3) ? r2 : r3;
            hi2_reg <= (r2 < r3) ? r3 : r2;
        end
        if (cmd.emit)
        begin
            out_reg.channel           <= ch_reg;
            out_reg.raw_distance      <= dist_reg;
            out_reg.filtered_distance <= mid_sum[uerm_pkg::DIST_W:1];
            out_reg.last              <= last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire

[src/ultrasonic_echo_ranger_median_top.sv]
// Each falling edge passes the scan, multiply, ring-write, sort and emit
// states; emit holds until the output register is free. Further edges of one
// sample follow, lowest channel first; no new sample is taken until all are served.
// The next sample is taken while the last result waits in the output register.
// Reset (rst_n, async, active low): speed 3435, echo history, rise times,
// rings and ring pointers cleared; no result pending.
`default_nettype none

module ultrasonic_echo_ranger_median_top (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire uerm_pkg::uerm_in_t           in_data,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output uerm_pkg::uerm_out_t               out_data,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [uerm_pkg::SPEED_W-1:0] cfg_data
);

    uerm_pkg::uerm_cmd_t  cmd;
    uerm_pkg::uerm_stat_t stat;

    // Speed register accepts a write in any cycle
    assign cfg_ready = 1'b1;

    uerm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    uerm_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire
